// ----- rtl/core/qrs_pkg.sv -----
package qrs_pkg;

    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int VALUE_W  = 34;
    localparam int DISC_W   = 34;
    // Square root of |D| * 2^(2*FRAC_W): one result bit per cell.
    localparam int ROOT_W   = (DISC_W + 2 * FRAC_W) / 2;
    localparam int SQ_REM_W = ROOT_W + 2;
    // |2a| needs one bit more than a.
    localparam int DEN_W    = COEF_W + 1;
    localparam int NUM_W    = VALUE_W + 1;
    localparam int SQ_CELLS = ROOT_W;
    localparam int DV_CELLS = VALUE_W;

    typedef enum logic [1:0] {
        CASE_TWO_REAL = 2'd0,
        CASE_DOUBLE   = 2'd1,
        CASE_COMPLEX  = 2'd2,
        CASE_A_ZERO   = 2'd3
    } t_root_case;

    typedef struct packed {
        logic                       valid;
        logic [SQ_REM_W-1:0]        rem;
        logic [ROOT_W-1:0]          root;
        logic [DISC_W-1:0]          mag;
        logic signed [COEF_W-1:0]   a;
        logic signed [COEF_W-1:0]   b;
        logic [DISC_W-1:0]          disc;
        t_root_case                 rcase;
    } t_sq_stage;

    typedef struct packed {
        logic                       valid;
        logic [DEN_W-1:0]           rem1;
        logic [DEN_W-1:0]           rem2;
        logic [VALUE_W-1:0]         q1;
        logic [VALUE_W-1:0]         q2;
        logic [VALUE_W-1:0]         n1;
        logic [VALUE_W-1:0]         n2;
        logic [DEN_W-1:0]           den;
        logic                       neg1;
        logic                       neg2;
        logic [DISC_W-1:0]          disc;
        t_root_case                 rcase;
    } t_dv_stage;

endpackage

// ----- rtl/core/quadratic_root_solver.sv -----
// Quadratic root solver for a*x*x + b*x + c with signed 16-bit coefficients.
// Input channel: i_valid with i_coef_a, i_coef_b, i_coef_c; a request is taken
// at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid with o_root_case, o_first_value, o_second_value and
// o_discriminant; a request is delivered where o_valid is high and i_stall low.
// Values carry 16 fraction bits and are truncated toward zero.
// The pipeline is stage 0 for the products, stage 1 for the discriminant,
// 33 square root cells (one root bit each), the register that forms the
// numerators, 34 divider cells (one quotient bit each) and the output register.
// Throughput is one request per cycle unless the receiver stalls; every cell
// hands its data to the next cell whenever the chain advances.
// When the receiver stalls while a result waits in the output register, the
// whole chain holds and o_stall rises in the same cycle; it falls as soon as
// the result is taken.
// Reset (synchronous, active low) clears every valid bit; nothing else is kept
// between requests.
module quadratic_root_solver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0]  i_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]  i_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]  i_coef_c,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_root_case,
    output logic signed [qrs_pkg::VALUE_W-1:0] o_first_value,
    output logic signed [qrs_pkg::VALUE_W-1:0] o_second_value,
    output logic signed [qrs_pkg::DISC_W-1:0]  o_discriminant
);
    import qrs_pkg::*;

    localparam int PROD_W = 2 * COEF_W;

    // The chain advances unless a finished result is being held back.
    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Stage 0: register the coefficients together with b*b and a*c.
    logic                      r_s0_valid;
    logic signed [COEF_W-1:0]  r_s0_a;
    logic signed [COEF_W-1:0]  r_s0_b;
    logic signed [PROD_W-1:0]  r_s0_bb;
    logic signed [PROD_W-1:0]  r_s0_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_valid;
            r_s0_a     <= i_coef_a;
            r_s0_b     <= i_coef_b;
            r_s0_bb    <= i_coef_b * i_coef_b;
            r_s0_ac    <= i_coef_a * i_coef_c;
        end
    end

    // Stage 1: discriminant, its magnitude and the case code.
    t_sq_stage                 r_s1;
    t_sq_stage                 n_s1;
    logic signed [DISC_W-1:0]  disc;

    always_comb begin
        disc = DISC_W'(r_s0_bb) - (DISC_W'(r_s0_ac) <<< 2);
        n_s1       = '0;
        n_s1.valid = r_s0_valid;
        n_s1.a     = r_s0_a;
        n_s1.b     = r_s0_b;
        n_s1.disc  = disc;
        // The most negative discriminant stays above -2^33, so the magnitude fits.
        n_s1.mag   = disc[DISC_W-1] ? DISC_W'(-disc) : DISC_W'(disc);
        if (r_s0_a == '0) begin
            n_s1.rcase = CASE_A_ZERO;
        end else if (disc[DISC_W-1]) begin
            n_s1.rcase = CASE_COMPLEX;
        end else if (disc == '0) begin
            n_s1.rcase = CASE_DOUBLE;
        end else begin
            n_s1.rcase = CASE_TWO_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (adv) begin
            r_s1 <= n_s1;
        end
    end

    // Square root chain: the radicand is |D| followed by 2*FRAC_W zero bits.
    t_sq_stage sq [0:SQ_CELLS];
    assign sq[0] = r_s1;

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_stage (sq[k]),
            .o_stage (sq[k+1])
        );
    end

    // Numerator stage: pick the two dividends for the case and split off signs.
    t_sq_stage                 sq_end;
    t_dv_stage                 r_prep;
    t_dv_stage                 n_prep;
    logic signed [NUM_W-1:0]   base;
    logic signed [NUM_W-1:0]   root_x;
    logic signed [NUM_W-1:0]   num1;
    logic signed [NUM_W-1:0]   num2;
    logic signed [DEN_W-1:0]   a_x;

    assign sq_end = sq[SQ_CELLS];

    always_comb begin
        a_x    = DEN_W'(sq_end.a);
        base   = -(NUM_W'(sq_end.b) <<< FRAC_W);
        root_x = NUM_W'({1'b0, sq_end.root});
        case (sq_end.rcase)
            CASE_TWO_REAL: begin
                num1 = base + root_x;
                num2 = base - root_x;
            end
            CASE_DOUBLE: begin
                num1 = base;
                num2 = base;
            end
            CASE_COMPLEX: begin
                num1 = base;
                num2 = root_x;
            end
            default: begin
                num1 = '0;
                num2 = '0;
            end
        endcase
        n_prep       = '0;
        n_prep.valid = sq_end.valid;
        n_prep.disc  = sq_end.disc;
        n_prep.rcase = sq_end.rcase;
        // Numerator magnitudes stay below 2^34 for every coefficient set.
        n_prep.n1    = num1[NUM_W-1] ? VALUE_W'(-num1) : VALUE_W'(num1);
        n_prep.n2    = num2[NUM_W-1] ? VALUE_W'(-num2) : VALUE_W'(num2);
        n_prep.neg1  = num1[NUM_W-1] ^ a_x[DEN_W-1];
        n_prep.neg2  = num2[NUM_W-1] ^ a_x[DEN_W-1];
        // |2a| as an unsigned divisor; a zero divisor only reaches the zero case.
        n_prep.den   = a_x[DEN_W-1] ? DEN_W'(-(a_x <<< 1)) : DEN_W'(a_x <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else if (adv) begin
            r_prep <= n_prep;
        end
    end

    // Divider chain: two lanes share the divisor, one quotient bit per cell.
    t_dv_stage dv [0:DV_CELLS];
    assign dv[0] = r_prep;

    for (genvar k = 0; k < DV_CELLS; k++) begin : g_div
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_stage (dv[k]),
            .o_stage (dv[k+1])
        );
    end

    // Output register. Quotient magnitudes stay below 2^33 here, so the signed
    // result always fits and no saturation is needed. A zero divisor leaves an
    // all-ones quotient, so the zero leading coefficient case forces both values
    // to zero.
    t_dv_stage                  dv_end;
    logic                       r_out_valid;
    t_root_case                 r_out_case;
    logic signed [VALUE_W-1:0]  r_out_first;
    logic signed [VALUE_W-1:0]  r_out_second;
    logic signed [DISC_W-1:0]   r_out_disc;

    assign dv_end = dv[DV_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid  <= dv_end.valid;
            r_out_case   <= dv_end.rcase;
            r_out_disc   <= dv_end.disc;
            if (dv_end.rcase == CASE_A_ZERO) begin
                r_out_first  <= '0;
                r_out_second <= '0;
            end else begin
                r_out_first  <= dv_end.neg1 ? -dv_end.q1 : dv_end.q1;
                r_out_second <= dv_end.neg2 ? -dv_end.q2 : dv_end.q2;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_root_case    = r_out_case;
    assign o_first_value  = r_out_first;
    assign o_second_value = r_out_second;
    assign o_discriminant = r_out_disc;

    a_zero_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_case == CASE_A_ZERO) |->
            (o_first_value == '0 && o_second_value == '0))
        else $error("zero leading coefficient gave nonzero values");

    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_case == CASE_DOUBLE) |->
            (o_first_value == o_second_value && o_discriminant == '0))
        else $error("double root values differ");

    a_complex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_case == CASE_COMPLEX) |-> o_discriminant[DISC_W-1])
        else $error("complex case with nonnegative discriminant");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

endmodule

// ----- rtl/core/qrs_sqrt_cell.sv -----
module qrs_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qrs_pkg::t_sq_stage i_stage,
    output qrs_pkg::t_sq_stage o_stage
);
    import qrs_pkg::*;

    t_sq_stage             r_stage;
    t_sq_stage             n_stage;
    logic [SQ_REM_W+1:0]   rem_sh;
    logic [SQ_REM_W+1:0]   trial;
    logic                  take;

    // One digit of the square root: bring down the next pair of radicand bits.
    always_comb begin
        rem_sh  = {i_stage.rem, i_stage.mag[DISC_W-1 -: 2]};
        trial   = (SQ_REM_W + 2)'({i_stage.root, 2'b01});
        take    = rem_sh >= trial;
        n_stage = i_stage;
        n_stage.mag  = {i_stage.mag[DISC_W-3:0], 2'b00};
        n_stage.rem  = take ? SQ_REM_W'(rem_sh - trial) : SQ_REM_W'(rem_sh);
        n_stage.root = {i_stage.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- rtl/core/qrs_div_cell.sv -----
module qrs_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qrs_pkg::t_dv_stage i_stage,
    output qrs_pkg::t_dv_stage o_stage
);
    import qrs_pkg::*;

    t_dv_stage         r_stage;
    t_dv_stage         n_stage;
    logic [DEN_W:0]    sh1;
    logic [DEN_W:0]    sh2;
    logic [DEN_W:0]    den_x;
    logic              ge1;
    logic              ge2;

    // One restoring quotient bit for each of the two lanes.
    always_comb begin
        den_x = {1'b0, i_stage.den};
        sh1   = {i_stage.rem1, i_stage.n1[VALUE_W-1]};
        sh2   = {i_stage.rem2, i_stage.n2[VALUE_W-1]};
        ge1   = sh1 >= den_x;
        ge2   = sh2 >= den_x;
        n_stage = i_stage;
        n_stage.rem1 = ge1 ? DEN_W'(sh1 - den_x) : DEN_W'(sh1);
        n_stage.rem2 = ge2 ? DEN_W'(sh2 - den_x) : DEN_W'(sh2);
        n_stage.q1   = {i_stage.q1[VALUE_W-2:0], ge1};
        n_stage.q2   = {i_stage.q2[VALUE_W-2:0], ge2};
        n_stage.n1   = {i_stage.n1[VALUE_W-2:0], 1'b0};
        n_stage.n2   = {i_stage.n2[VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule
